### hdl/cts_pkg.sv
// Shared types and constants of the configurable token splitter.
`default_nettype none
package cts_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_SPACE_CHARS = 3'd0;
    localparam logic [2:0] CFG_SPACE_COUNT = 3'd1;
    localparam logic [2:0] CFG_OPEN_CHARS  = 3'd2;
    localparam logic [2:0] CFG_OPEN_COUNT  = 3'd3;
    localparam logic [2:0] CFG_CLOSE_CHARS = 3'd4;
    localparam logic [2:0] CFG_CLOSE_COUNT = 3'd5;
    localparam logic [2:0] CFG_MAX_LENGTH  = 3'd6;

    // Reset contents: whitespace " \f\n\r\t\v", no comment starts, stops "\n\r"
    localparam logic [63:0] RST_SPACE_CHARS = 64'd12133501373472;
    localparam logic [3:0]  RST_SPACE_COUNT = 4'd6;
    localparam logic [63:0] RST_OPEN_CHARS  = 64'd0;
    localparam logic [3:0]  RST_OPEN_COUNT  = 4'd0;
    localparam logic [63:0] RST_CLOSE_CHARS = 64'd3338;
    localparam logic [3:0]  RST_CLOSE_COUNT = 4'd2;
    localparam logic [7:0]  RST_MAX_LENGTH  = 8'd255;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_SKIP    = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_TOKEN   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_CUT  = 2'd2,
        KIND_EOI  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [63:0] space_chars;
        logic [3:0]  space_count;
        logic [63:0] open_chars;
        logic [3:0]  open_count;
        logic [63:0] close_chars;
        logic [3:0]  close_count;
        logic [7:0]  max_length;
    } t_cfg;

    // One queued action. A pair is a cut followed by the byte that opens the
    // next token; len then holds the cut length and kind is not used.
    typedef struct packed {
        logic       pair;
        t_kind      kind;
        logic [7:0] chr;
        logic [7:0] len;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage
`default_nettype wire

### hdl/configurable_token_splitter.sv
// Top level of the configurable token splitter: configuration registers and wiring.
//
// Usage: one text byte per request enters on the input channel (i_in_valid,
// o_in_stall, i_in_byte, i_end_of_input). Results leave on the output channel
// (o_out_valid, i_out_stall, o_kind, o_token_char, o_token_length). A request
// is taken at a clock edge where valid is high and stall is low.
// Each byte yields zero, one or two results; a cut at the length limit gives
// two (the cut, then the byte that opens the new token).
// A taken byte passes into the action queue, then into the output register.
// Throughput: one byte per cycle while results keep up; a cut adds a second
// result, absorbed by the four-entry queue when cuts are sparse, while a run
// of cuts (limit of one) stalls the input once the queue is full.
// When the receiver stalls, the output holds and the queue fills; o_in_stall
// rises only when the queue is full. Comment bytes, and separator bytes outside a
// token, yield no result at all.
// Reset (synchronous, active low) empties the queue, drops any result,
// returns to the skipping mode and loads the default character sets.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data,
// one register per cycle; the user must write it only while the block is
// idle, and the block itself does not enforce this.
`default_nettype none
module configurable_token_splitter
    import cts_pkg::*;
#(
    parameter int SET_SLOTS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_end_of_input,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_token_char,
    output logic [7:0]       o_token_length
);

    t_cfg          r_cfg;
    t_entry        w_entry, w_head;
    t_queue_status w_queue;
    logic          w_push, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.space_chars <= RST_SPACE_CHARS;
            r_cfg.space_count <= RST_SPACE_COUNT;
            r_cfg.open_chars  <= RST_OPEN_CHARS;
            r_cfg.open_count  <= RST_OPEN_COUNT;
            r_cfg.close_chars <= RST_CLOSE_CHARS;
            r_cfg.close_count <= RST_CLOSE_COUNT;
            r_cfg.max_length  <= RST_MAX_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SPACE_CHARS: r_cfg.space_chars <= i_cfg_data;
                CFG_SPACE_COUNT: r_cfg.space_count <= i_cfg_data[3:0];
                CFG_OPEN_CHARS:  r_cfg.open_chars  <= i_cfg_data;
                CFG_OPEN_COUNT:  r_cfg.open_count  <= i_cfg_data[3:0];
                CFG_CLOSE_CHARS: r_cfg.close_chars <= i_cfg_data;
                CFG_CLOSE_COUNT: r_cfg.close_count <= i_cfg_data[3:0];
                CFG_MAX_LENGTH:  r_cfg.max_length  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    cts_front #(
        .SET_SLOTS(SET_SLOTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .i_queue        (w_queue),
        .o_push         (w_push),
        .o_entry        (w_entry)
    );

    cts_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_queue)
    );

    cts_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_queue        (w_queue),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_token_char   (o_token_char),
        .o_token_length (o_token_length)
    );

endmodule
`default_nettype wire

### hdl/cts_front.sv
// Front end: classifies each text byte and tracks token and comment state.
`default_nettype none
module cts_front
    import cts_pkg::*;
#(
    parameter int SET_SLOTS = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cfg          i_cfg,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_end_of_input,
    input  wire t_queue_status i_queue,
    output logic               o_push,
    output t_entry             o_entry
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_count, n_count;
    logic       w_accept, w_has_entry;
    logic       w_ws, w_open, w_close;
    logic [7:0] w_limit;

    function automatic logic set_match(input logic [63:0] chars, input logic [3:0] count,
                                       input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < SET_SLOTS; k++) begin
            if ((4'(k) < count) && (chars[8*k +: 8] == b)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    assign o_in_stall = i_queue.full;
    assign w_accept   = i_in_valid && !i_queue.full;
    assign o_push     = w_accept && w_has_entry;

    assign w_ws    = set_match(i_cfg.space_chars, i_cfg.space_count, i_in_byte);
    assign w_open  = !w_ws && set_match(i_cfg.open_chars, i_cfg.open_count, i_in_byte);
    assign w_close = set_match(i_cfg.close_chars, i_cfg.close_count, i_in_byte);
    assign w_limit = (i_cfg.max_length == 8'd0) ? 8'd1 : i_cfg.max_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SKIP;
            r_count <= 8'd0;
        end else if (w_accept) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_mode        = r_mode;
        n_count       = r_count;
        w_has_entry   = 1'b0;
        o_entry.pair  = 1'b0;
        o_entry.kind  = KIND_BYTE;
        o_entry.chr   = 8'd0;
        o_entry.len   = 8'd0;
        if (i_end_of_input) begin
            w_has_entry = 1'b1;
            if (r_mode == MODE_TOKEN) begin
                o_entry.kind = KIND_END;
                o_entry.len  = r_count;
            end else begin
                o_entry.kind = KIND_EOI;
            end
            n_mode  = MODE_SKIP;
            n_count = 8'd0;
        end else begin
            case (r_mode)
                MODE_COMMENT: begin
                    if (w_close) begin
                        n_mode = MODE_SKIP;
                    end
                end
                MODE_TOKEN: begin
                    w_has_entry = 1'b1;
                    if (w_ws || w_open) begin
                        o_entry.kind = KIND_END;
                        o_entry.len  = r_count;
                        n_count      = 8'd0;
                        n_mode       = w_open ? MODE_COMMENT : MODE_SKIP;
                    end else if (r_count < w_limit) begin
                        n_count      = r_count + 8'd1;
                        o_entry.chr  = i_in_byte;
                        o_entry.len  = r_count + 8'd1;
                    end else begin
                        // Token full: cut it, this byte opens the next token.
                        o_entry.pair = 1'b1;
                        o_entry.chr  = i_in_byte;
                        o_entry.len  = r_count;
                        n_count      = 8'd1;
                    end
                end
                default: begin
                    if (w_ws) begin
                        n_mode = MODE_SKIP;
                    end else if (w_open) begin
                        n_mode = MODE_COMMENT;
                    end else begin
                        n_mode       = MODE_TOKEN;
                        n_count      = 8'd1;
                        w_has_entry  = 1'b1;
                        o_entry.chr  = i_in_byte;
                        o_entry.len  = 8'd1;
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### hdl/cts_queue.sv
// Short register queue between the front end and the output stage.
`default_nettype none
module cts_queue
    import cts_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_entry  i_entry,
    input  wire logic    i_pop,
    output t_entry       o_head,
    output t_queue_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

### hdl/cts_back.sv
// Output stage: turns queued actions into requests on the result channel.
`default_nettype none
module cts_back
    import cts_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_entry        i_head,
    input  wire t_queue_status i_queue,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_token_char,
    output logic [7:0]         o_token_length
);

    logic       r_valid, n_valid;
    logic       r_second, n_second;
    t_kind      r_kind, n_kind;
    logic [7:0] r_chr, n_chr;
    logic [7:0] r_len, n_len;
    logic       w_load;

    assign w_load = !r_valid || !i_out_stall;

    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        n_kind   = r_kind;
        n_chr    = r_chr;
        n_len    = r_len;
        o_pop    = 1'b0;
        if (w_load) begin
            n_valid = !i_queue.empty;
            if (!i_queue.empty) begin
                if (i_head.pair && !r_second) begin
                    // First half of a cut; the entry stays for the byte.
                    n_kind   = KIND_CUT;
                    n_chr    = 8'd0;
                    n_len    = i_head.len;
                    n_second = 1'b1;
                end else if (i_head.pair) begin
                    n_kind   = KIND_BYTE;
                    n_chr    = i_head.chr;
                    n_len    = 8'd1;
                    n_second = 1'b0;
                    o_pop    = 1'b1;
                end else begin
                    n_kind = i_head.kind;
                    n_chr  = i_head.chr;
                    n_len  = i_head.len;
                    o_pop  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_chr  <= n_chr;
        r_len  <= n_len;
    end

    assign o_out_valid    = r_valid;
    assign o_kind         = r_kind;
    assign o_token_char   = r_chr;
    assign o_token_length = r_len;

endmodule
`default_nettype wire

### hdl/cts_checker.sv
// Port-level checker for the configurable token splitter and its bind.
`default_nettype none
module cts_checker
    import cts_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [7:0]  i_in_byte,
    input wire logic        i_end_of_input,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_kind,
    input wire logic [7:0]  o_token_char,
    input wire logic [7:0]  o_token_length
);

    logic w_out_take;
    assign w_out_take = o_out_valid && !i_out_stall;

    // A cut is always followed at once by the byte that opens the next token.
    a_cut_then_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_take && (o_kind == KIND_CUT) |=>
            o_out_valid && (o_kind == KIND_BYTE) && (o_token_length == 8'd1))
        else $error("cut not followed by a first token byte");

    a_char_only_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != KIND_BYTE) |-> (o_token_char == 8'd0))
        else $error("character present on a result that is not a token byte");

    a_length_by_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_kind == KIND_EOI) == (o_token_length == 8'd0)))
        else $error("token length inconsistent with result kind");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_kind) && $stable(o_token_char)
            && $stable(o_token_length))
        else $error("stalled result changed");

    // A stalled input request stays offered and unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=>
            i_in_valid && $stable(i_in_byte) && $stable(i_end_of_input))
        else $error("stalled input request changed");

endmodule

bind configurable_token_splitter cts_checker u_cts_checker (.*);
`default_nettype wire
